### rtl/stt_pkg.sv
// Shared types, character codes and token kinds for the source text tokenizer.
package stt_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int WIDE_BITS         = 64;
    localparam int SLOT_COUNT        = 3;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_INTEGER = 4'd1;
    localparam logic [3:0] KIND_FLOAT   = 4'd2;
    localparam logic [3:0] KIND_STRING  = 4'd3;
    localparam logic [3:0] KIND_IDENT   = 4'd4;
    localparam logic [3:0] KIND_ASSIGN  = 4'd5;
    localparam logic [3:0] KIND_SEMI    = 4'd6;
    localparam logic [3:0] KIND_LPAREN  = 4'd7;
    localparam logic [3:0] KIND_RPAREN  = 4'd8;
    localparam logic [3:0] KIND_LCURLY  = 4'd9;
    localparam logic [3:0] KIND_RCURLY  = 4'd10;
    localparam logic [3:0] KIND_END     = 4'd11;

    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_LCURLY = 8'h7B;
    localparam logic [7:0] CHAR_RCURLY = 8'h7D;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_start;
        logic [31:0] token_length;
    } out_item_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0]            mask;
        out_item_t [SLOT_COUNT-1:0]       tok;
    } bundle_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) ||
               ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z));
    endfunction

endpackage

### rtl/source_text_tokenizer.sv
// Source text tokenizer top level: scanner, bundle queue and token emitter.
// Takes one byte per cycle while the queue is not full; a byte may complete up to
// three tokens. Tokens pass through the bundle queue, then the output register,
// which sends one token per cycle unless stalled; a four-bundle queue absorbs bursts.
// Reset clears the scan state and queue; position restarts at zero.
module source_text_tokenizer #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  stt_pkg::in_item_t  byte_item,
    output logic               token_valid,
    input  logic               token_stall,
    output stt_pkg::out_item_t token_item
);
    import stt_pkg::*;

    logic    push;
    bundle_t push_data;
    logic    full;
    logic    empty;
    logic    pop;
    bundle_t head;

    stt_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    stt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .head      (head)
    );

    stt_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule

### rtl/stt_scan.sv
// Front end: scans one byte per cycle unless full; bundles the tokens it completes.
module stt_scan #(
    parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  stt_pkg::in_item_t byte_item,
    output logic              push,
    output stt_pkg::bundle_t  push_data,
    input  logic              full
);
    import stt_pkg::*;

    localparam int W = POSITION_BITS;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_NUMBER  = 7'b0000010,
        MODE_STRING  = 7'b0000100,
        MODE_IDENT   = 7'b0001000,
        MODE_UNKNOWN = 7'b0010000,
        MODE_COLON   = 7'b0100000,
        MODE_COLONEQ = 7'b1000000
    } mode_t;

    mode_t        mode_reg, mode_next;
    logic [W-1:0] pos_reg, pos_next;
    logic [W-1:0] start_reg, start_next;
    logic [W-1:0] len_reg, len_next;
    logic         digit_reg, digit_next;
    logic [1:0]   dot_reg, dot_next;

    logic [7:0]   c;
    logic         fin;
    logic         accept;
    logic         rescan;
    bundle_t      bundle;

    function automatic logic [W-1:0] sat_inc(input logic [W-1:0] v);
        return (&v) ? v : v + W'(1);
    endfunction

    function automatic logic [31:0] out32(input logic [W-1:0] v);
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(v);
        return (|wide[WIDE_BITS-1:32]) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    function automatic logic [3:0] number_kind(input logic digit, input logic [1:0] dots);
        logic [3:0] k;
        if (!digit || dots >= 2'd2)
        begin
            k = KIND_UNKNOWN;
        end
        else if (dots == 2'd1)
        begin
            k = KIND_FLOAT;
        end
        else
        begin
            k = KIND_INTEGER;
        end
        return k;
    endfunction

    function automatic out_item_t make_tok(input logic [3:0] kind, input logic [W-1:0] s,
                                           input logic [W-1:0] l);
        out_item_t t;
        t.token_kind   = kind;
        t.token_start  = out32(s);
        t.token_length = out32(l);
        return t;
    endfunction

    assign c          = byte_item.text_byte;
    assign fin        = byte_item.final_byte;
    assign byte_stall = full;
    assign accept     = byte_valid && !full;
    assign push       = accept && (|bundle.mask);
    assign push_data  = bundle;

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        digit_next = digit_reg;
        dot_next   = dot_reg;
        rescan     = 1'b0;
        bundle     = '0;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit(c) || c == CHAR_DOT)
                begin
                    len_next = sat_inc(len_reg);
                    if (is_digit(c))
                    begin
                        digit_next = 1'b1;
                    end
                    else if (dot_reg < 2'd2)
                    begin
                        dot_next = dot_reg + 2'd1;
                    end
                end
                else
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(number_kind(digit_reg, dot_reg),
                                              start_reg, len_reg);
                    mode_next = MODE_IDLE;
                    rescan    = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (c == CHAR_QUOTE)
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(KIND_STRING, start_reg, len_reg);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = sat_inc(len_reg);
                end
            end
            MODE_IDENT:
            begin
                if (is_alpha(c) || is_digit(c) || c == CHAR_UNDER)
                begin
                    len_next = sat_inc(len_reg);
                end
                else
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(KIND_IDENT, start_reg, len_reg);
                    mode_next = MODE_IDLE;
                    rescan    = 1'b1;
                end
            end
            MODE_COLON:
            begin
                if (c == CHAR_EQUAL)
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_COLONEQ;
                end
                else if (is_space(c))
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(KIND_UNKNOWN, start_reg, len_reg);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_UNKNOWN;
                end
            end
            MODE_COLONEQ:
            begin
                if (is_space(c))
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(KIND_ASSIGN, start_reg, W'(2));
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next  = sat_inc(len_reg);
                    mode_next = MODE_UNKNOWN;
                end
            end
            MODE_UNKNOWN:
            begin
                if (is_space(c))
                begin
                    bundle.mask[0] = 1'b1;
                    bundle.tok[0]  = make_tok(KIND_UNKNOWN, start_reg, len_reg);
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    len_next = sat_inc(len_reg);
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                rescan    = 1'b1;
            end
        endcase

        // start of a new token from the idle state
        if (rescan && !is_space(c))
        begin
            if (is_digit(c) || c == CHAR_DOT)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                len_next   = W'(1);
                digit_next = is_digit(c);
                dot_next   = (c == CHAR_DOT) ? 2'd1 : 2'd0;
            end
            else if (c == CHAR_QUOTE)
            begin
                mode_next  = MODE_STRING;
                start_next = sat_inc(pos_reg);
                len_next   = '0;
            end
            else if (is_alpha(c))
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                len_next   = W'(1);
            end
            else if (c == CHAR_COLON)
            begin
                mode_next  = MODE_COLON;
                start_next = pos_reg;
                len_next   = W'(1);
            end
            else if (c == CHAR_SEMI)
            begin
                bundle.mask[1] = 1'b1;
                bundle.tok[1]  = make_tok(KIND_SEMI, pos_reg, W'(1));
            end
            else if (c == CHAR_LPAREN)
            begin
                bundle.mask[1] = 1'b1;
                bundle.tok[1]  = make_tok(KIND_LPAREN, pos_reg, W'(1));
            end
            else if (c == CHAR_RPAREN)
            begin
                bundle.mask[1] = 1'b1;
                bundle.tok[1]  = make_tok(KIND_RPAREN, pos_reg, W'(1));
            end
            else if (c == CHAR_LCURLY)
            begin
                bundle.mask[1] = 1'b1;
                bundle.tok[1]  = make_tok(KIND_LCURLY, pos_reg, W'(1));
            end
            else if (c == CHAR_RCURLY)
            begin
                bundle.mask[1] = 1'b1;
                bundle.tok[1]  = make_tok(KIND_RCURLY, pos_reg, W'(1));
            end
            else
            begin
                mode_next  = MODE_UNKNOWN;
                start_next = pos_reg;
                len_next   = W'(1);
            end
        end

        pos_next = sat_inc(pos_reg);

        // flush pending token, then close the text
        if (fin)
        begin
            if (mode_next != MODE_IDLE)
            begin
                bundle.mask[1] = 1'b1;
                if (mode_next == MODE_NUMBER)
                begin
                    bundle.tok[1] = make_tok(number_kind(digit_next, dot_next),
                                             start_next, len_next);
                end
                else if (mode_next == MODE_STRING)
                begin
                    bundle.tok[1] = make_tok(KIND_STRING, start_next, len_next);
                end
                else if (mode_next == MODE_IDENT)
                begin
                    bundle.tok[1] = make_tok(KIND_IDENT, start_next, len_next);
                end
                else
                begin
                    bundle.tok[1] = make_tok(KIND_UNKNOWN, start_next, len_next);
                end
            end
            bundle.mask[2] = 1'b1;
            bundle.tok[2]  = make_tok(KIND_END, pos_next, '0);
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            digit_next = 1'b0;
            dot_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            digit_reg <= 1'b0;
            dot_reg   <= 2'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            digit_reg <= digit_next;
            dot_reg   <= dot_next;
        end
    end

endmodule

### rtl/stt_queue.sv
// Short bundle queue between the scanner and the token emitter.
module stt_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stt_pkg::bundle_t push_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output stt_pkg::bundle_t head
);
    import stt_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    bundle_t               store_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]     count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full    = (count_reg == (PTR_BITS + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (PTR_BITS + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (PTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/stt_emit.sv
// Back end: sends the tokens of each queued bundle in order through an output register.
module stt_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  stt_pkg::bundle_t  head,
    output logic              pop,
    output logic              token_valid,
    input  logic              token_stall,
    output stt_pkg::out_item_t token_item
);
    import stt_pkg::*;

    logic [SLOT_COUNT-1:0]         done_reg, done_next;
    logic                          out_valid_reg, out_valid_next;
    out_item_t                     out_item_reg;
    logic [SLOT_COUNT-1:0]         remain;
    logic [SLOT_COUNT-1:0]         pick;
    logic [$clog2(SLOT_COUNT)-1:0] sel;
    logic                          load;

    assign remain = head.mask & ~done_reg;
    assign load   = !empty && (!out_valid_reg || !token_stall);

    always_comb
    begin
        pick = '0;
        sel  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (remain[i])
            begin
                pick = '0;
                pick[i] = 1'b1;
                sel = ($clog2(SLOT_COUNT))'(i);
            end
        end
    end

    always_comb
    begin
        pop            = 1'b0;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            if ((remain & ~pick) == '0)
            begin
                pop       = 1'b1;
                done_next = '0;
            end
            else
            begin
                done_next = done_reg | pick;
            end
        end
        else if (!token_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= head.tok[sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_item  = out_item_reg;

endmodule

### tb/tb_source_text_tokenizer.sv
// Testbench for source_text_tokenizer: directed byte table plus random text.
module tb_source_text_tokenizer;
    import stt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AFTER   = 40;

    typedef enum logic [6:0] {
        SCAN_IDLE    = 7'b0000001,
        SCAN_NUMBER  = 7'b0000010,
        SCAN_STRING  = 7'b0000100,
        SCAN_IDENT   = 7'b0001000,
        SCAN_UNKNOWN = 7'b0010000,
        SCAN_COLON   = 7'b0100000,
        SCAN_COLONEQ = 7'b1000000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic [1:0] typed_n;
        out_item_t  t0;
        out_item_t  t1;
    } text_row_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      token_valid;
    logic      token_stall;
    out_item_t token_item;

    scan_mode_t  scan_mode;
    logic [31:0] scan_pos;
    logic [31:0] run_start;
    logic [31:0] run_len;
    logic        seen_digit;
    logic [1:0]  dot_tally;

    out_item_t   step_tokens[$];
    out_item_t   expected_tokens[$];
    out_item_t   want;
    text_row_t   directed_rows[$];
    logic [7:0]  lexeme[$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int tokens_seen;
    int cycle_count;
    int sent_count;
    int hold_left;
    bit hold_done;
    int phase_items[3] = '{140, 140, 120};

    source_text_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic out_item_t tok(input logic [3:0] k, input logic [31:0] s,
                                      input logic [31:0] l);
        out_item_t t;
        t.token_kind   = k;
        t.token_start  = s;
        t.token_length = l;
        return t;
    endfunction

    function automatic void note_step(input out_item_t t);
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void add_expected(input out_item_t t);
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void add_lexeme(input logic [7:0] c);
        lexeme.insert(lexeme.size(), c);
    endfunction

    function automatic text_row_t plain(input logic [7:0] ch, input logic fin);
        text_row_t r;
        r     = '0;
        r.ch  = ch;
        r.fin = fin;
        return r;
    endfunction

    function automatic text_row_t typed_row(input logic [7:0] ch, input logic fin,
                                            input logic [1:0] n, input out_item_t t0,
                                            input out_item_t t1);
        text_row_t r;
        r         = plain(ch, fin);
        r.typed   = 1'b1;
        r.typed_n = n;
        r.t0      = t0;
        r.t1      = t1;
        return r;
    endfunction

    function automatic void add_row(input text_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic numeral(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) ||
               ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z));
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (&v) ? v : v + 32'd1;
    endfunction

    function automatic void clear_scan();
        scan_mode  = SCAN_IDLE;
        scan_pos   = '0;
        run_start  = '0;
        run_len    = '0;
        seen_digit = 1'b0;
        dot_tally  = '0;
    endfunction

    function automatic logic [3:0] number_kind();
        if (!seen_digit || (dot_tally >= 2'd2))
            return KIND_UNKNOWN;
        return (dot_tally == 2'd1) ? KIND_FLOAT : KIND_INTEGER;
    endfunction

    function automatic void start_run(input scan_mode_t m, input logic [31:0] s,
                                      input logic [31:0] l);
        scan_mode = m;
        run_start = s;
        run_len   = l;
    endfunction

    function automatic void open_token(input logic [7:0] c, input logic [31:0] p);
        if (blank(c))
            return;
        if (numeral(c) || (c == CHAR_DOT))
        begin
            start_run(SCAN_NUMBER, p, 32'd1);
            seen_digit = numeral(c);
            dot_tally  = (c == CHAR_DOT) ? 2'd1 : 2'd0;
        end
        else if (c == CHAR_QUOTE)
            start_run(SCAN_STRING, bump(p), 32'd0);
        else if (letter(c))
            start_run(SCAN_IDENT, p, 32'd1);
        else if (c == CHAR_COLON)
            start_run(SCAN_COLON, p, 32'd1);
        else if (c == CHAR_SEMI)
            note_step(tok(KIND_SEMI, p, 32'd1));
        else if (c == CHAR_LPAREN)
            note_step(tok(KIND_LPAREN, p, 32'd1));
        else if (c == CHAR_RPAREN)
            note_step(tok(KIND_RPAREN, p, 32'd1));
        else if (c == CHAR_LCURLY)
            note_step(tok(KIND_LCURLY, p, 32'd1));
        else if (c == CHAR_RCURLY)
            note_step(tok(KIND_RCURLY, p, 32'd1));
        else
            start_run(SCAN_UNKNOWN, p, 32'd1);
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic fin);
        logic [31:0] p;
        logic        rescan;
        p      = scan_pos;
        rescan = 1'b0;
        step_tokens.delete();
        case (scan_mode)
            SCAN_NUMBER:
            begin
                if (numeral(c) || (c == CHAR_DOT))
                begin
                    run_len = bump(run_len);
                    if (numeral(c))
                        seen_digit = 1'b1;
                    else if (dot_tally < 2'd2)
                        dot_tally = dot_tally + 2'd1;
                end
                else
                begin
                    note_step(tok(number_kind(), run_start, run_len));
                    rescan = 1'b1;
                end
            end
            SCAN_STRING:
            begin
                if (c == CHAR_QUOTE)
                begin
                    note_step(tok(KIND_STRING, run_start, run_len));
                    scan_mode = SCAN_IDLE;
                end
                else
                    run_len = bump(run_len);
            end
            SCAN_IDENT:
            begin
                if (letter(c) || numeral(c) || (c == CHAR_UNDER))
                    run_len = bump(run_len);
                else
                begin
                    note_step(tok(KIND_IDENT, run_start, run_len));
                    rescan = 1'b1;
                end
            end
            SCAN_COLON:
            begin
                if (c == CHAR_EQUAL)
                begin
                    run_len   = bump(run_len);
                    scan_mode = SCAN_COLONEQ;
                end
                else if (blank(c))
                begin
                    note_step(tok(KIND_UNKNOWN, run_start, run_len));
                    scan_mode = SCAN_IDLE;
                end
                else
                begin
                    run_len   = bump(run_len);
                    scan_mode = SCAN_UNKNOWN;
                end
            end
            SCAN_COLONEQ:
            begin
                if (blank(c))
                begin
                    note_step(tok(KIND_ASSIGN, run_start, 32'd2));
                    scan_mode = SCAN_IDLE;
                end
                else
                begin
                    run_len   = bump(run_len);
                    scan_mode = SCAN_UNKNOWN;
                end
            end
            SCAN_UNKNOWN:
            begin
                if (blank(c))
                begin
                    note_step(tok(KIND_UNKNOWN, run_start, run_len));
                    scan_mode = SCAN_IDLE;
                end
                else
                    run_len = bump(run_len);
            end
            default:
                rescan = 1'b1;
        endcase
        if (rescan)
        begin
            scan_mode = SCAN_IDLE;
            open_token(c, p);
        end
        scan_pos = bump(p);
        if (fin)
        begin
            case (scan_mode)
                SCAN_IDLE:
                    ;
                SCAN_NUMBER:
                    note_step(tok(number_kind(), run_start, run_len));
                SCAN_STRING:
                    note_step(tok(KIND_STRING, run_start, run_len));
                SCAN_IDENT:
                    note_step(tok(KIND_IDENT, run_start, run_len));
                default:
                    note_step(tok(KIND_UNKNOWN, run_start, run_len));
            endcase
            note_step(tok(KIND_END, scan_pos, 32'd0));
            clear_scan();
        end
    endfunction

    function automatic logic [7:0] pick_digit();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_letter();
        return ($urandom_range(0, 1) ? CHAR_LOW_A : CHAR_UP_A) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] pick_blank();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? CHAR_SPACE : CHAR_TAB + 8'(n);
    endfunction

    task automatic compose_lexeme();
        int         len;
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0, 1, 2:
            begin
                len = $urandom_range(1, 6);
                repeat (len) add_lexeme(pick_digit());
            end
            3, 4:
            begin
                repeat ($urandom_range(1, 4)) add_lexeme(pick_digit());
                add_lexeme(CHAR_DOT);
                repeat ($urandom_range(0, 4)) add_lexeme(pick_digit());
            end
            5:
            begin
                repeat ($urandom_range(1, 5))
                    add_lexeme($urandom_range(0, 1) ? CHAR_DOT : pick_digit());
            end
            6, 7:
            begin
                add_lexeme(pick_letter());
                repeat ($urandom_range(0, 6))
                begin
                    case ($urandom_range(0, 2))
                        0: add_lexeme(pick_letter());
                        1: add_lexeme(pick_digit());
                        default: add_lexeme(CHAR_UNDER);
                    endcase
                end
            end
            8:
            begin
                add_lexeme(CHAR_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    c = 8'($urandom_range(0, 255));
                    add_lexeme((c == CHAR_QUOTE) ? CHAR_UNDER : c);
                end
                if ($urandom_range(0, 3) != 0)
                    add_lexeme(CHAR_QUOTE);
            end
            9:
            begin
                add_lexeme(CHAR_COLON);
                add_lexeme(CHAR_EQUAL);
                add_lexeme(pick_blank());
            end
            10:
            begin
                case ($urandom_range(0, 4))
                    0: add_lexeme(CHAR_SEMI);
                    1: add_lexeme(CHAR_LPAREN);
                    2: add_lexeme(CHAR_RPAREN);
                    3: add_lexeme(CHAR_LCURLY);
                    default: add_lexeme(CHAR_RCURLY);
                endcase
            end
            11:
            begin
                add_lexeme(CHAR_COLON);
                if ($urandom_range(0, 1))
                    add_lexeme(CHAR_EQUAL);
                add_lexeme(8'($urandom_range(0, 255)));
            end
            12:
            begin
                repeat ($urandom_range(1, 4)) add_lexeme(8'($urandom_range(128, 255)));
            end
            13:
                add_lexeme(8'($urandom_range(0, 255)));
            default:
                ;
        endcase
        if ($urandom_range(0, 9) < 7)
            add_lexeme(pick_blank());
    endtask

    task automatic send_byte(input text_row_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= {r.ch, r.fin};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        predict_byte(r.ch, r.fin);
        if (r.typed)
        begin
            if (r.typed_n > 2'd0)
                add_expected(r.t0);
            if (r.typed_n > 2'd1)
                add_expected(r.t1);
        end
        else
        begin
            foreach (step_tokens[i])
                add_expected(step_tokens[i]);
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && token_valid && !token_stall)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
            begin
                $error("unexpected token: kind %0d start %0d length %0d",
                       token_item.token_kind, token_item.token_start, token_item.token_length);
                errors++;
            end
            else
            begin
                want = expected_tokens.pop_front();
                if (token_item.token_kind !== want.token_kind)
                begin
                    $error("token_kind: expected %0d, actual %0d",
                           want.token_kind, token_item.token_kind);
                    errors++;
                end
                if (token_item.token_start !== want.token_start)
                begin
                    $error("token_start: expected %0d, actual %0d",
                           want.token_start, token_item.token_start);
                    errors++;
                end
                if (token_item.token_length !== want.token_length)
                begin
                    $error("token_length: expected %0d, actual %0d",
                           want.token_length, token_item.token_length);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        token_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                token_stall <= 1'b1;
                hold_left--;
            end
            else if (!hold_done && (tokens_seen >= HOLD_AFTER))
            begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES - 1;
                token_stall <= 1'b1;
            end
            else
                token_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_item      = '0;
        errors         = 0;
        tokens_seen    = 0;
        cycle_count    = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        send_idle_pct  = 34;
        recv_stall_pct = 49;
        clear_scan();

        add_row(typed_row(CHAR_SEMI, 1'b1, 2'd2,
                          tok(KIND_SEMI, 0, 1), tok(KIND_END, 1, 0)));
        add_row(typed_row(CHAR_LPAREN, 1'b0, 2'd1, tok(KIND_LPAREN, 0, 1), '0));
        add_row(typed_row(CHAR_RPAREN, 1'b0, 2'd1, tok(KIND_RPAREN, 1, 1), '0));
        add_row(typed_row(CHAR_LCURLY, 1'b0, 2'd1, tok(KIND_LCURLY, 2, 1), '0));
        add_row(typed_row(CHAR_RCURLY, 1'b0, 2'd1, tok(KIND_RCURLY, 3, 1), '0));
        add_row(typed_row(8'hFF, 1'b1, 2'd2,
                          tok(KIND_UNKNOWN, 4, 1), tok(KIND_END, 5, 0)));
        add_row(typed_row(CHAR_COLON, 1'b0, 2'd0, '0, '0));
        add_row(typed_row(CHAR_EQUAL, 1'b1, 2'd2,
                          tok(KIND_UNKNOWN, 0, 2), tok(KIND_END, 2, 0)));
        add_row(typed_row(8'h00, 1'b1, 2'd2,
                          tok(KIND_UNKNOWN, 0, 1), tok(KIND_END, 1, 0)));
        add_row(plain(CHAR_DOT, 1'b0));
        add_row(plain(CHAR_SPACE, 1'b0));
        add_row(plain(CHAR_ZERO + 8'd1, 1'b0));
        add_row(plain(CHAR_DOT, 1'b0));
        add_row(plain(CHAR_LOW_A + 8'd23, 1'b0));
        add_row(plain(CHAR_UNDER, 1'b0));
        add_row(plain(CHAR_COLON, 1'b0));
        add_row(plain(CHAR_EQUAL, 1'b0));
        add_row(plain(CHAR_TAB, 1'b0));
        add_row(plain(CHAR_COLON, 1'b0));
        add_row(plain(CHAR_LOW_A + 8'd23, 1'b0));
        add_row(plain(CHAR_SPACE, 1'b0));
        add_row(plain(CHAR_DOT, 1'b0));
        add_row(plain(CHAR_DOT, 1'b0));
        add_row(plain(CHAR_ZERO + 8'd7, 1'b0));
        add_row(plain(CHAR_SEMI, 1'b1));
        add_row(plain(CHAR_QUOTE, 1'b0));
        add_row(plain(CHAR_LOW_A + 8'd16, 1'b1));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i]);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 49;
                end
                1:
                begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 34;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (ph == 1)
            begin
                byte_valid <= 1'b0;
                while (expected_tokens.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            sent_count = 0;
            while (sent_count < phase_items[ph])
            begin
                compose_lexeme();
                while (lexeme.size() != 0)
                begin
                    send_byte(plain(lexeme.pop_front(), $urandom_range(0, 49) == 0));
                    sent_count++;
                end
            end
        end

        byte_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
